// ----- rtl/lpmr_pkg.sv -----
// Shared types and constants of the length-prefixed message ring.
`default_nettype none
package lpmr_pkg;

   localparam int SIZE_W = 13;
   localparam int LEN_W  = 12;
   localparam int CNT_W  = 11;
   localparam int BYTE_W = 8;
   localparam int REQ_W  = 2;
   localparam int STAT_W = 3;

   localparam int HEADER_BYTES = 4;

   localparam logic [REQ_W-1:0] REQ_PUT_HDR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_PUT_BYTE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_GET      = 2'd2;

   localparam logic CSR_RING_SIZE = 1'b0;
   localparam logic CSR_READ_ONLY = 1'b1;

   localparam logic [SIZE_W-1:0] RESET_RING_SIZE = 13'd4096;
   localparam logic [SIZE_W-1:0] MIN_RING_SIZE   = 13'd16;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_NO_ROOM   = 3'd1,
      STAT_TOO_LONG  = 3'd2,
      STAT_READ_ONLY = 3'd3,
      STAT_EMPTY     = 3'd4,
      STAT_BUF_SMALL = 3'd5,
      STAT_SEQ_ERR   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUT_HDR,
      ST_GET_HDR,
      ST_GET_CHECK
   } state_type;

   // Configuration as seen by the sequencer
   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              read_only;
      logic              clear;
   } cfg_type;

endpackage
`default_nettype wire

// ----- rtl/lpmr_ram.sv -----
// Byte store of the ring: one write port, one registered read port.
`default_nettype none
module lpmr_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [AW-1:0]              waddr,
   input  wire logic [lpmr_pkg::BYTE_W-1:0] wdata,
   input  wire logic                       re,
   input  wire logic [AW-1:0]              raddr,
   output logic      [lpmr_pkg::BYTE_W-1:0] rdata
);
   import lpmr_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- rtl/lpmr_ctrl.sv -----
// Sequencer of the message ring: pointers, counts, header walk and result registers.
`default_nettype none
module lpmr_ctrl #(
   parameter int AW = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lpmr_pkg::cfg_type           cfg,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [lpmr_pkg::REQ_W-1:0]  req_type,
   input  wire logic [lpmr_pkg::LEN_W-1:0]  req_msg_len,
   input  wire logic [lpmr_pkg::BYTE_W-1:0] req_data_byte,
   input  wire logic [lpmr_pkg::SIZE_W-1:0] req_buf_size,
   output logic                             rsp_strobe,
   output logic [lpmr_pkg::STAT_W-1:0]      rsp_status,
   output logic [lpmr_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                             rsp_byte_valid,
   output logic [lpmr_pkg::LEN_W-1:0]       rsp_out_len,
   output logic                             rsp_last,
   output logic [lpmr_pkg::SIZE_W-1:0]      rsp_free_bytes,
   output logic                             ram_we,
   output logic [AW-1:0]                    ram_waddr,
   output logic [lpmr_pkg::BYTE_W-1:0]      ram_wdata,
   output logic                             ram_re,
   output logic [AW-1:0]                    ram_raddr,
   input  wire logic [lpmr_pkg::BYTE_W-1:0] ram_rdata
);
   import lpmr_pkg::*;

   localparam int CW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
   localparam logic [SIZE_W-1:0] HDR_SZ = SIZE_W'(HEADER_BYTES);

   function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [SIZE_W-1:0] sz);
      logic [CW-1:0] n;
      n = CW'(p) + CW'(1);
      return (n >= CW'(sz)) ? '0 : AW'(n);
   endfunction

   state_type         state_ff, state_in;
   logic [1:0]        step_ff, step_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     scan_ff, scan_in;
   logic [SIZE_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0]  msg_cnt_ff, msg_cnt_in;
   logic [LEN_W-1:0]  put_rem_ff, put_rem_in;
   logic [LEN_W-1:0]  put_len_ff, put_len_in;
   logic [LEN_W-1:0]  get_rem_ff, get_rem_in;
   logic [LEN_W-1:0]  get_len_ff, get_len_in;
   logic [LEN_W-1:0]  hdr_len_ff, hdr_len_in;
   logic [SIZE_W-1:0] bsize_ff, bsize_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ram_ff, rsp_ram_in;

   logic              accept;
   logic [SIZE_W-1:0] need;
   logic              put_ok;
   logic              get_new;

   assign busy    = (state_ff != ST_IDLE) || cfg.clear;
   assign accept  = start && !busy;
   assign need    = HDR_SZ + {1'b0, req_msg_len};
   assign put_ok  = (put_rem_ff == '0) && !cfg.read_only && (need <= cfg.size)
                    && (free_ff >= need);
   assign get_new = (get_rem_ff == '0) && (msg_cnt_ff != '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_PUT_HDR) && put_ok) begin
               state_in = ST_PUT_HDR;
            end else if (accept && (req_type == REQ_GET) && get_new) begin
               state_in = ST_GET_HDR;
            end
         end
         ST_PUT_HDR: begin
            if (step_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         ST_GET_HDR: begin
            if (step_ff == 2'd2) begin
               state_in = ST_GET_CHECK;
            end
         end
         ST_GET_CHECK: state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
      if (cfg.clear) begin
         state_in = ST_IDLE;
      end
   end

   // Datapath and outputs
   always_comb begin
      step_in       = step_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      scan_in       = scan_ff;
      free_in       = free_ff;
      msg_cnt_in    = msg_cnt_ff;
      put_rem_in    = put_rem_ff;
      put_len_in    = put_len_ff;
      get_rem_in    = get_rem_ff;
      get_len_in    = get_len_ff;
      hdr_len_in    = hdr_len_ff;
      bsize_in      = bsize_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ram_in    = rsp_ram_ff;
      ram_we        = 1'b0;
      ram_waddr     = wr_ptr_ff;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = rd_ptr_ff;

      if (cfg.clear) begin
         rd_ptr_in  = '0;
         wr_ptr_in  = '0;
         free_in    = cfg.size;
         msg_cnt_in = '0;
         put_rem_in = '0;
         put_len_in = '0;
         get_rem_in = '0;
         get_len_in = '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_len_in    = '0;
                  rsp_last_in   = 1'b0;
                  rsp_ram_in    = 1'b0;
                  case (req_type)
                     REQ_PUT_HDR: begin
                        if (put_rem_ff != '0) begin
                           rsp_status_in = STAT_SEQ_ERR;
                        end else begin
                           rsp_len_in = req_msg_len;
                           if (cfg.read_only) begin
                              rsp_status_in = STAT_READ_ONLY;
                           end else if (need > cfg.size) begin
                              rsp_status_in = STAT_TOO_LONG;
                           end else if (free_ff < need) begin
                              rsp_status_in = STAT_NO_ROOM;
                           end else begin
                              // reserve now, write the header beats next
                              rsp_strobe_in = 1'b0;
                              free_in       = free_ff - need;
                              put_len_in    = req_msg_len;
                              put_rem_in    = req_msg_len;
                              hdr_len_in    = req_msg_len;
                              step_in       = '0;
                              if (req_msg_len == '0) begin
                                 msg_cnt_in  = msg_cnt_ff + CNT_W'(1);
                                 rsp_last_in = 1'b1;
                              end
                           end
                        end
                     end
                     REQ_PUT_BYTE: begin
                        if (put_rem_ff == '0) begin
                           rsp_status_in = STAT_SEQ_ERR;
                        end else begin
                           ram_we     = 1'b1;
                           ram_wdata  = req_data_byte;
                           wr_ptr_in  = adv(wr_ptr_ff, cfg.size);
                           put_rem_in = put_rem_ff - LEN_W'(1);
                           rsp_len_in = put_len_ff;
                           if (put_rem_ff == LEN_W'(1)) begin
                              msg_cnt_in  = msg_cnt_ff + CNT_W'(1);
                              rsp_last_in = 1'b1;
                           end
                        end
                     end
                     REQ_GET: begin
                        if (get_rem_ff != '0) begin
                           ram_re     = 1'b1;
                           rd_ptr_in  = adv(rd_ptr_ff, cfg.size);
                           get_rem_in = get_rem_ff - LEN_W'(1);
                           rsp_len_in = get_len_ff;
                           rsp_ram_in = 1'b1;
                           if (get_rem_ff == LEN_W'(1)) begin
                              msg_cnt_in  = msg_cnt_ff - CNT_W'(1);
                              free_in     = free_ff + HDR_SZ + {1'b0, get_len_ff};
                              get_len_in  = '0;
                              rsp_last_in = 1'b1;
                           end
                        end else if (msg_cnt_ff == '0) begin
                           rsp_status_in = STAT_EMPTY;
                        end else begin
                           // fetch header byte 0, walk the rest with the scan pointer
                           rsp_strobe_in = 1'b0;
                           ram_re        = 1'b1;
                           scan_in       = adv(rd_ptr_ff, cfg.size);
                           bsize_in      = req_buf_size;
                           step_in       = '0;
                        end
                     end
                     default: rsp_status_in = STAT_SEQ_ERR;
                  endcase
               end
            end
            ST_PUT_HDR: begin
               ram_we    = 1'b1;
               wr_ptr_in = adv(wr_ptr_ff, cfg.size);
               step_in   = step_ff + 2'd1;
               case (step_ff)
                  2'd0:    ram_wdata = hdr_len_ff[7:0];
                  2'd1:    ram_wdata = {4'd0, hdr_len_ff[11:8]};
                  default: ram_wdata = '0;
               endcase
               if (step_ff == 2'd3) begin
                  rsp_strobe_in = 1'b1;
               end
            end
            ST_GET_HDR: begin
               scan_in = adv(scan_ff, cfg.size);
               step_in = step_ff + 2'd1;
               case (step_ff)
                  2'd0: begin
                     hdr_len_in[7:0] = ram_rdata;
                     ram_re          = 1'b1;
                     ram_raddr       = scan_ff;
                  end
                  2'd1:    hdr_len_in[11:8] = ram_rdata[3:0];
                  default: ;
               endcase
            end
            ST_GET_CHECK: begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_len_in    = hdr_len_ff;
               if (bsize_ff < {1'b0, hdr_len_ff}) begin
                  rsp_status_in = STAT_BUF_SMALL;
               end else begin
                  rd_ptr_in  = scan_ff;
                  get_len_in = hdr_len_ff;
                  if (hdr_len_ff == '0) begin
                     msg_cnt_in  = msg_cnt_ff - CNT_W'(1);
                     free_in     = free_ff + HDR_SZ;
                     get_len_in  = '0;
                     rsp_last_in = 1'b1;
                  end else begin
                     ram_re     = 1'b1;
                     ram_raddr  = scan_ff;
                     rd_ptr_in  = adv(scan_ff, cfg.size);
                     get_rem_in = hdr_len_ff - LEN_W'(1);
                     rsp_ram_in = 1'b1;
                     if (hdr_len_ff == LEN_W'(1)) begin
                        msg_cnt_in  = msg_cnt_ff - CNT_W'(1);
                        free_in     = free_ff + HDR_SZ + {1'b0, hdr_len_ff};
                        get_len_in  = '0;
                        rsp_last_in = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         free_ff       <= '0;
         msg_cnt_ff    <= '0;
         put_rem_ff    <= '0;
         put_len_ff    <= '0;
         get_rem_ff    <= '0;
         get_len_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_ram_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         free_ff       <= free_in;
         msg_cnt_ff    <= msg_cnt_in;
         put_rem_ff    <= put_rem_in;
         put_len_ff    <= put_len_in;
         get_rem_ff    <= get_rem_in;
         get_len_ff    <= get_len_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_ram_ff    <= rsp_ram_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      hdr_len_ff    <= hdr_len_in;
      bsize_ff      <= bsize_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_byte   = rsp_ram_ff ? ram_rdata : '0;
   assign rsp_byte_valid = rsp_ram_ff;
   assign rsp_out_len    = rsp_len_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_free_bytes = free_ff;

endmodule
`default_nettype wire

// ----- rtl/length_prefixed_message_ring_top.sv -----
// Top level of the length-prefixed message ring: configuration registers and the ring.
//
//   channel  direction  handshake                 payload
//   req_     in         start & !busy             req_type, req_msg_len, req_data_byte,
//                                                 req_buf_size
//   rsp_     out        rsp_strobe, one cycle     rsp_status, rsp_out_byte, rsp_byte_valid,
//                                                 rsp_out_len, rsp_last, rsp_free_bytes
//   csr_     in         csr_we                    csr_index, csr_wdata
//
// Data put and data get beats leave busy low; the result shows in the cycle after
// the accepting edge while the next beat may already be taken. Rejected and error
// beats also leave busy low, but for a get refused for a small buffer. An accepted
// put header and the get that opens a message hold busy while the ring's byte ports
// walk the 4 header bytes, and their result is strobed once the walk ends. After
// reset and after each ring_size write the queue empties while the clear holds busy.
// Each result stands for exactly one cycle; the receiver cannot stall.
`default_nettype none
module length_prefixed_message_ring_top #(
   parameter int RING_BYTES = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [lpmr_pkg::REQ_W-1:0]  req_type,
   input  wire logic [lpmr_pkg::LEN_W-1:0]  req_msg_len,
   input  wire logic [lpmr_pkg::BYTE_W-1:0] req_data_byte,
   input  wire logic [lpmr_pkg::SIZE_W-1:0] req_buf_size,
   output logic                             rsp_strobe,
   output logic [lpmr_pkg::STAT_W-1:0]      rsp_status,
   output logic [lpmr_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                             rsp_byte_valid,
   output logic [lpmr_pkg::LEN_W-1:0]       rsp_out_len,
   output logic                             rsp_last,
   output logic [lpmr_pkg::SIZE_W-1:0]      rsp_free_bytes,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [lpmr_pkg::SIZE_W-1:0] csr_wdata
);
   import lpmr_pkg::*;

   localparam int AW = $clog2(RING_BYTES);
   localparam logic [SIZE_W-1:0] RING_CAP =
      (RING_BYTES > 8191) ? 13'd8191 : SIZE_W'(RING_BYTES);

   logic [SIZE_W-1:0] ring_size_ff, ring_size_in;
   logic              read_only_ff, read_only_in;
   logic              clear_ff, clear_in;
   logic [SIZE_W-1:0] eff_size;
   cfg_type           cfg;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   always_comb begin
      ring_size_in = ring_size_ff;
      read_only_in = read_only_ff;
      clear_in     = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_RING_SIZE: begin
               ring_size_in = csr_wdata;
               clear_in     = 1'b1;
            end
            CSR_READ_ONLY: read_only_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clear is registered alongside the ring size so the sequencer sees the new size
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RESET_RING_SIZE;
         read_only_ff <= 1'b0;
         clear_ff     <= 1'b1;
      end else begin
         ring_size_ff <= ring_size_in;
         read_only_ff <= read_only_in;
         clear_ff     <= clear_in;
      end
   end

   always_comb begin
      if (ring_size_ff < MIN_RING_SIZE) begin
         eff_size = MIN_RING_SIZE;
      end else if (ring_size_ff > RING_CAP) begin
         eff_size = RING_CAP;
      end else begin
         eff_size = ring_size_ff;
      end
   end

   assign cfg.size      = eff_size;
   assign cfg.read_only = read_only_ff;
   assign cfg.clear     = clear_ff;

   lpmr_ram #(
      .DEPTH (RING_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   lpmr_ctrl #(
      .AW (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_msg_len    (req_msg_len),
      .req_data_byte  (req_data_byte),
      .req_buf_size   (req_buf_size),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_out_len    (rsp_out_len),
      .rsp_last       (rsp_last),
      .rsp_free_bytes (rsp_free_bytes),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_re         (ram_re),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata)
   );

endmodule
`default_nettype wire

// ----- bench/length_prefixed_message_ring_top_test.sv -----
// Self-checking bench for the message ring: random put/get beats against a predictor.
`timescale 1ns / 100ps
module length_prefixed_message_ring_top_test;
   import lpmr_pkg::*;

   localparam int RING_BYTES  = 4096;
   localparam int STALL_LIMIT = 2000;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      status_type        stat;
      logic [BYTE_W-1:0] data;
      logic              data_ok;
      logic [LEN_W-1:0]  len;
      logic              last;
      logic [SIZE_W-1:0] free_left;
   } reply_type;

   class ring_tracker;
      reply_type         awaited[$];
      logic [BYTE_W-1:0] ring [RING_BYTES];
      int                rd_ptr, wr_ptr, free_cnt;
      int                put_left, put_len, get_left, get_len;
      logic [CNT_W-1:0]  msg_cnt;
      logic [SIZE_W-1:0] size_reg;
      logic              ro;
      int                mismatches, beats, replies, messages_read, bytes_read;
      int                status_seen [8];

      function new();
         size_reg = RESET_RING_SIZE;
         ro = 1'b0;
         mismatches = 0;
         beats = 0;
         replies = 0;
         messages_read = 0;
         bytes_read = 0;
         foreach (status_seen[k]) status_seen[k] = 0;
         empty_ring();
      endfunction

      function int span();
         int s;
         s = int'(size_reg);
         if (s < int'(MIN_RING_SIZE)) s = int'(MIN_RING_SIZE);
         if (s > RING_BYTES) s = RING_BYTES;
         return s;
      endfunction

      function int step(int p);
         return (p + 1 >= span()) ? 0 : p + 1;
      endfunction

      function void empty_ring();
         rd_ptr = 0;
         wr_ptr = 0;
         free_cnt = span();
         msg_cnt = '0;
         put_left = 0;
         put_len = 0;
         get_left = 0;
         get_len = 0;
      endfunction

      function void write_csr(logic idx, logic [SIZE_W-1:0] val);
         if (idx == CSR_RING_SIZE) begin
            size_reg = val;
            empty_ring();
         end else begin
            ro = val[0];
         end
      endfunction

      // Hand back header and data space once the last byte of a message is read.
      function void close_get();
         msg_cnt = msg_cnt - 1'b1;
         free_cnt = free_cnt + HEADER_BYTES + get_len;
         get_len = 0;
      endfunction

      function void accept_beat(logic [REQ_W-1:0] kind, logic [LEN_W-1:0] len,
                                logic [BYTE_W-1:0] dbyte, logic [SIZE_W-1:0] bsize);
         reply_type r;
         int        need, mlen, p, i;
         r = '0;
         r.stat = STAT_OK;
         beats++;
         case (kind)
            REQ_PUT_HDR: begin
               if (put_left != 0) begin
                  r.stat = STAT_SEQ_ERR;
               end else begin
                  need = HEADER_BYTES + int'(len);
                  r.len = len;
                  if (ro) r.stat = STAT_READ_ONLY;
                  else if (need > span()) r.stat = STAT_TOO_LONG;
                  else if (free_cnt < need) r.stat = STAT_NO_ROOM;
                  else begin
                     // little-endian length header
                     for (i = 0; i < HEADER_BYTES; i++) begin
                        ring[wr_ptr] = 8'(32'(len) >> (8 * i));
                        wr_ptr = step(wr_ptr);
                     end
                     free_cnt = free_cnt - need;
                     put_len = int'(len);
                     put_left = int'(len);
                     if (len == 0) begin
                        msg_cnt = msg_cnt + 1'b1;
                        r.last = 1'b1;
                     end
                  end
               end
            end
            REQ_PUT_BYTE: begin
               if (put_left == 0) begin
                  r.stat = STAT_SEQ_ERR;
               end else begin
                  ring[wr_ptr] = dbyte;
                  wr_ptr = step(wr_ptr);
                  put_left--;
                  r.len = LEN_W'(put_len);
                  if (put_left == 0) begin
                     msg_cnt = msg_cnt + 1'b1;
                     r.last = 1'b1;
                  end
               end
            end
            REQ_GET: begin
               if (get_left != 0) begin
                  r.data = ring[rd_ptr];
                  r.data_ok = 1'b1;
                  rd_ptr = step(rd_ptr);
                  r.len = LEN_W'(get_len);
                  get_left--;
                  if (get_left == 0) begin
                     close_get();
                     r.last = 1'b1;
                  end
               end else if (msg_cnt == 0) begin
                  r.stat = STAT_EMPTY;
               end else begin
                  mlen = 0;
                  p = rd_ptr;
                  for (i = 0; i < HEADER_BYTES; i++) begin
                     mlen = mlen | (int'(ring[p]) << (8 * i));
                     p = step(p);
                  end
                  mlen = mlen & 'hFFF;
                  r.len = LEN_W'(mlen);
                  if (int'(bsize) < mlen) begin
                     // message stays at the head
                     r.stat = STAT_BUF_SMALL;
                  end else begin
                     rd_ptr = p;
                     get_len = mlen;
                     if (mlen == 0) begin
                        close_get();
                        r.last = 1'b1;
                     end else begin
                        r.data = ring[rd_ptr];
                        r.data_ok = 1'b1;
                        rd_ptr = step(rd_ptr);
                        get_left = mlen - 1;
                        if (get_left == 0) begin
                           close_get();
                           r.last = 1'b1;
                        end
                     end
                  end
               end
            end
            default: r.stat = STAT_SEQ_ERR;
         endcase
         r.free_left = free_cnt[SIZE_W-1:0];
         status_seen[r.stat]++;
         if (r.data_ok) bytes_read++;
         if (kind == REQ_GET && r.stat == STAT_OK && r.last) messages_read++;
         awaited.push_back(r);
      endfunction

      function void compare_reply(logic [STAT_W-1:0] st, logic [BYTE_W-1:0] data,
                                  logic data_ok, logic [LEN_W-1:0] len, logic last,
                                  logic [SIZE_W-1:0] free_left);
         reply_type e;
         bit        bad;
         bad = 0;
         if (awaited.size() == 0) begin
            $error("reply beat with nothing awaited (status %0d)", st);
            mismatches++;
            return;
         end
         e = awaited.pop_front();
         replies++;
         if (st !== e.stat) begin
            $error("status: expected %0d, got %0d", e.stat, st);
            bad = 1;
         end
         if (data !== e.data) begin
            $error("out_byte: expected %0d, got %0d", e.data, data);
            bad = 1;
         end
         if (data_ok !== e.data_ok) begin
            $error("byte_valid: expected %0d, got %0d", e.data_ok, data_ok);
            bad = 1;
         end
         if (len !== e.len) begin
            $error("out_len: expected %0d, got %0d", e.len, len);
            bad = 1;
         end
         if (last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last);
            bad = 1;
         end
         if (free_left !== e.free_left) begin
            $error("free_bytes: expected %0d, got %0d", e.free_left, free_left);
            bad = 1;
         end
         if (bad) mismatches++;
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [REQ_W-1:0]    req_type;
   logic [LEN_W-1:0]    req_msg_len;
   logic [BYTE_W-1:0]   req_data_byte;
   logic [SIZE_W-1:0]   req_buf_size;
   logic                rsp_strobe;
   logic [STAT_W-1:0]   rsp_status;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic [LEN_W-1:0]    rsp_out_len;
   logic                rsp_last;
   logic [SIZE_W-1:0]   rsp_free_bytes;
   logic                csr_we;
   logic                csr_index;
   logic [SIZE_W-1:0]   csr_wdata;

   ring_tracker tracker;
   int          idle_cycles = 0;

   // ring size per phase (-1: leave it), read-only flag and beat count
   int ring_sizes  [7] = '{4096, 16, 0, 8191, 100, -1, 37};
   int ro_flags    [7] = '{0, 0, 0, 0, 0, 1, 0};
   int phase_beats [7] = '{250, 200, 120, 220, 180, 90, 240};

   length_prefixed_message_ring_top #(.RING_BYTES(RING_BYTES)) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_msg_len    (req_msg_len),
      .req_data_byte  (req_data_byte),
      .req_buf_size   (req_buf_size),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_out_len    (rsp_out_len),
      .rsp_last       (rsp_last),
      .rsp_free_bytes (rsp_free_bytes),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Reply side: the block cannot be stalled, so take every strobed beat.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe === 1'b1)
            tracker.compare_reply(rsp_status, rsp_out_byte, rsp_byte_valid, rsp_out_len,
                                  rsp_last, rsp_free_bytes);
         if (rsp_strobe === 1'b1 || (start === 1'b1 && busy === 1'b0)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $error("no beat moved for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // Hold the beat until an edge with busy low takes it, and note it there.
   task automatic drive_beat(input logic [REQ_W-1:0] kind, input logic [LEN_W-1:0] len,
                             input logic [BYTE_W-1:0] dbyte, input logic [SIZE_W-1:0] bsize);
      req_type      <= kind;
      req_msg_len   <= len;
      req_data_byte <= dbyte;
      req_buf_size  <= bsize;
      start         <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.accept_beat(kind, len, dbyte, bsize);
   endtask

   task automatic write_csr(input logic idx, input logic [SIZE_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tracker.write_csr(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_replies();
      start <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_gap(bit burst);
      int pick;
      pick = $urandom_range(99, 0);
      if (burst || pick < 55) return 0;
      if (pick < 88) return $urandom_range(3, 1);
      if (pick < 97) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // Mostly well-formed put and get sequences, with stray and unknown beats mixed in.
   task automatic random_beat();
      int               pick, room;
      logic [REQ_W-1:0] kind;
      logic [LEN_W-1:0] len;
      logic [SIZE_W-1:0] bsize;
      pick  = $urandom_range(99, 0);
      len   = LEN_W'($urandom);
      bsize = SIZE_W'($urandom);
      if (tracker.put_left != 0 && tracker.get_left != 0)
         kind = pick < 50 ? REQ_PUT_BYTE : pick < 95 ? REQ_GET :
                pick < 98 ? REQ_PUT_HDR : REQ_UNUSED;
      else if (tracker.put_left != 0)
         kind = pick < 82 ? REQ_PUT_BYTE : pick < 92 ? REQ_GET :
                pick < 96 ? REQ_PUT_HDR : REQ_UNUSED;
      else if (tracker.get_left != 0)
         kind = pick < 70 ? REQ_GET : pick < 90 ? REQ_PUT_HDR :
                pick < 95 ? REQ_PUT_BYTE : REQ_UNUSED;
      else
         kind = pick < 44 ? REQ_PUT_HDR : pick < 88 ? REQ_GET :
                pick < 95 ? REQ_PUT_BYTE : REQ_UNUSED;
      if (kind == REQ_PUT_HDR) begin
         pick = $urandom_range(99, 0);
         room = tracker.span() - HEADER_BYTES;
         if (room > 400) room = 400;
         if (pick < 65) len = LEN_W'($urandom_range(12, 0));
         else if (pick < 88) len = LEN_W'($urandom_range(64, 13));
         else if (pick < 96) len = LEN_W'($urandom_range(room, 0));
      end
      if (kind == REQ_GET && tracker.get_left == 0 && $urandom_range(99, 0) < 12)
         bsize = SIZE_W'($urandom_range(15, 0));
      drive_beat(kind, len, 8'($urandom), bsize);
   endtask

   initial begin
      int ph, n, gap;
      bit burst;
      tracker       = new();
      start         <= 1'b0;
      req_type      <= REQ_PUT_HDR;
      req_msg_len   <= '0;
      req_data_byte <= '0;
      req_buf_size  <= '0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_RING_SIZE;
      csr_wdata     <= '0;
      reset         <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed opening at the reset configuration
      drive_beat(REQ_GET,      12'd0,    8'h00, 13'd0);     // empty queue
      drive_beat(REQ_PUT_BYTE, 12'd5,    8'h3C, 13'd9);     // data with no open put
      drive_beat(REQ_UNUSED,   12'hFFF,  8'hFF, 13'h1FFF);
      drive_beat(REQ_PUT_HDR,  12'd0,    8'h11, 13'd0);     // zero-length message
      drive_beat(REQ_PUT_HDR,  12'd3,    8'h00, 13'd0);
      drive_beat(REQ_PUT_HDR,  12'd7,    8'h00, 13'd0);     // header while put open
      drive_beat(REQ_PUT_BYTE, 12'd0,    8'h00, 13'd0);
      drive_beat(REQ_PUT_BYTE, 12'hFFF,  8'hFF, 13'h1FFF);
      drive_beat(REQ_PUT_BYTE, 12'd0,    8'hA5, 13'd0);
      drive_beat(REQ_PUT_HDR,  12'hFFF,  8'h00, 13'd0);     // longer than the ring
      drive_beat(REQ_PUT_HDR,  12'd4092, 8'h00, 13'd0);     // fits the ring, not the room
      drive_beat(REQ_GET,      12'd0,    8'h00, 13'd0);     // zero-length read
      drive_beat(REQ_GET,      12'd0,    8'h00, 13'd2);     // buffer too small
      drive_beat(REQ_GET,      12'd0,    8'h00, 13'd3);     // buffer exactly fits
      drive_beat(REQ_GET,      12'hFFF,  8'hFF, 13'h1FFF);  // buf_size ignored mid-message
      drive_beat(REQ_GET,      12'd0,    8'h00, 13'd0);
      drive_beat(REQ_GET,      12'd0,    8'h00, 13'd0);     // empty again
      drive_beat(REQ_PUT_HDR,  12'd1,    8'h00, 13'd0);
      drive_beat(REQ_PUT_BYTE, 12'd0,    8'h5A, 13'd0);
      drive_beat(REQ_GET,      12'd0,    8'h00, 13'd1);     // one-byte message

      for (ph = 0; ph < 7; ph++) begin
         drain_replies();
         repeat (8) @(posedge clock);
         if (ring_sizes[ph] >= 0) write_csr(CSR_RING_SIZE, SIZE_W'(ring_sizes[ph]));
         write_csr(CSR_READ_ONLY, SIZE_W'(ro_flags[ph]));
         burst = 0;
         for (n = 0; n < phase_beats[ph]; n++) begin
            if (n % 40 == 0) burst = ($urandom_range(3, 0) == 0);
            if (n == phase_beats[ph] / 2) drain_replies();
            random_beat();
            gap = pick_gap(burst);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      drain_replies();
      repeat (10) @(posedge clock);

      if (tracker.awaited.size() != 0)
         $error("%0d replies never arrived", tracker.awaited.size());
      $write("covered %0d beats over 7 ring settings, %0d replies checked, ",
             tracker.beats, tracker.replies);
      $display("%0d messages (%0d bytes) read back",
               tracker.messages_read, tracker.bytes_read);
      $write("status mix: ok %0d, no room %0d, too long %0d, read only %0d, ",
             tracker.status_seen[STAT_OK], tracker.status_seen[STAT_NO_ROOM],
             tracker.status_seen[STAT_TOO_LONG], tracker.status_seen[STAT_READ_ONLY]);
      $display("empty %0d, small buffer %0d, sequence %0d",
               tracker.status_seen[STAT_EMPTY], tracker.status_seen[STAT_BUF_SMALL],
               tracker.status_seen[STAT_SEQ_ERR]);
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lpmr_pkg.sv
rtl/lpmr_ram.sv
rtl/lpmr_ctrl.sv
rtl/length_prefixed_message_ring_top.sv
bench/length_prefixed_message_ring_top_test.sv
